>>> rtl/core/pfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and helpers for the puzzle file checksum block.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam logic [2:0] REGION_HEADER   = 3'd0;
   localparam logic [2:0] REGION_SOLUTION = 3'd1;
   localparam logic [2:0] REGION_GRID     = 3'd2;
   localparam logic [2:0] REGION_TEXT     = 3'd3;
   localparam logic [2:0] REGION_NOTES    = 3'd4;

   localparam logic [15:0] VERSION_RESET     = 16'd13;
   localparam logic [15:0] NOTES_MIN_VERSION = 16'd13;

   localparam logic [7:0] KEY_I = 8'h49;
   localparam logic [7:0] KEY_C = 8'h43;
   localparam logic [7:0] KEY_H = 8'h48;
   localparam logic [7:0] KEY_E = 8'h45;
   localparam logic [7:0] KEY_A = 8'h41;
   localparam logic [7:0] KEY_T = 8'h54;
   localparam logic [7:0] KEY_D = 8'h44;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic [2:0] region;
      logic       count_notes;
      logic       last;
   } upd_type;

   typedef struct packed {
      logic [15:0] header;
      logic [15:0] solution;
      logic [15:0] grid;
      logic [15:0] text;
      logic [15:0] whole;
   } sums_type;

   function automatic logic [15:0] rot_add(input logic [15:0] sum, input logic [7:0] b);
      logic [15:0] r;
      r = {sum[0], sum[15:1]};
      return r + {8'd0, b};
   endfunction

   function automatic logic [63:0] mask_sums(input sums_type s);
      return {s.text[15:8] ^ KEY_D, s.grid[15:8] ^ KEY_E,
              s.solution[15:8] ^ KEY_T, s.header[15:8] ^ KEY_A,
              s.text[7:0] ^ KEY_E, s.grid[7:0] ^ KEY_H,
              s.solution[7:0] ^ KEY_C, s.header[7:0] ^ KEY_I};
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/pfc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_req_if / pfc_rsp_if
// Valid/ready channels for input bytes and checksum results.
// ----------------------------------------------------------------------------
interface pfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [2:0] region;
   logic       last_byte;

   modport source (output valid, data_byte, region, last_byte, input ready);
   modport sink   (input valid, data_byte, region, last_byte, output ready);
endinterface

interface pfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] header_sum;
   logic [15:0] primary_sum;
   logic [63:0] masked_sums;

   modport source (output valid, header_sum, primary_sum, masked_sums, input ready);
   modport sink   (input valid, header_sum, primary_sum, masked_sums, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pfc_sum_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_sum_bank
// The five rotate-add sums; one byte update per cycle, cleared after last.
// ----------------------------------------------------------------------------
module pfc_sum_bank (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfc_pkg::upd_type  upd,
   output pfc_pkg::sums_type      sums_next
);
   import pfc_pkg::*;

   sums_type sums_ff;
   sums_type sums_in;
   logic     counted;

   always_comb begin
      sums_next = sums_ff;
      counted   = 1'b1;
      case (upd.region)
         REGION_HEADER:   sums_next.header   = rot_add(sums_ff.header, upd.data_byte);
         REGION_SOLUTION: sums_next.solution = rot_add(sums_ff.solution, upd.data_byte);
         REGION_GRID:     sums_next.grid     = rot_add(sums_ff.grid, upd.data_byte);
         REGION_TEXT:     sums_next.text     = rot_add(sums_ff.text, upd.data_byte);
         REGION_NOTES: begin
            if (upd.count_notes) begin
               sums_next.text = rot_add(sums_ff.text, upd.data_byte);
            end else begin
               counted = 1'b0;
            end
         end
         default: counted = 1'b0;
      endcase
      if (counted) begin
         sums_next.whole = rot_add(sums_ff.whole, upd.data_byte);
      end
   end

   always_comb begin
      sums_in = sums_ff;
      if (upd.valid) begin
         sums_in = upd.last ? '0 : sums_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/puz_file_checksum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// puz_file_checksum
// Puzzle file checksum unit: five 16-bit rotate-right-and-add sums.
//
// req_if carries one byte per transaction with its region code and a last
// flag. Bytes of regions header, solution, grid and text update their own
// sum and the primary sum; notes count only when format_version >= 13.
// On the last byte one transaction leaves on rsp_if with the header sum,
// the primary sum and the eight masked checksum bytes; all sums then clear.
// csr_write_enable / csr_write_data write format_version (reset 13).
// The input register holds each byte, which then updates the sums; a result
// is registered for rsp_if when its last byte leaves the input register.
// Throughput: one byte per cycle, unless a last byte waits on a stalled rsp_if.
// Reset clears all sums, both pipeline stages, and sets format_version 13.
// While rsp_if is stalled, ordinary bytes keep flowing; a second last byte
// waits in the input register until the pending result is taken.
// ----------------------------------------------------------------------------
module puz_file_checksum (
   input  wire logic        clock,
   input  wire logic        reset,
   pfc_req_if.sink          req_if,
   pfc_rsp_if.source        rsp_if,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   import pfc_pkg::*;

   logic [15:0] version_ff;
   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic [2:0]  s1_region_ff;
   logic        s1_last_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_header_ff;
   logic [15:0] rsp_primary_ff;
   logic [63:0] rsp_masked_ff;

   logic        out_free;
   logic        s1_go;
   upd_type     upd;
   sums_type    sums_next;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_go        = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_go;

   assign upd.valid       = s1_go;
   assign upd.data_byte   = s1_byte_ff;
   assign upd.region      = s1_region_ff;
   assign upd.count_notes = (version_ff >= NOTES_MIN_VERSION);
   assign upd.last        = s1_last_ff;

   pfc_sum_bank u_sum_bank (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .sums_next (sums_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= VERSION_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            version_ff <= csr_write_data;
         end
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s1_go && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_byte_ff   <= req_if.data_byte;
         s1_region_ff <= req_if.region;
         s1_last_ff   <= req_if.last_byte;
      end
      if (s1_go && s1_last_ff) begin
         rsp_header_ff  <= sums_next.header;
         rsp_primary_ff <= sums_next.whole;
         rsp_masked_ff  <= mask_sums(sums_next);
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.header_sum  = rsp_header_ff;
   assign rsp_if.primary_sum = rsp_primary_ff;
   assign rsp_if.masked_sums = rsp_masked_ff;

endmodule
`default_nettype wire
